// ----- rtl/ascii_hex_sensor_record_parser_defines.svh -----
// Assertion macros used by the sensor record parser top level.
`ifndef ASCII_HEX_SENSOR_RECORD_PARSER_DEFINES_SVH
`define ASCII_HEX_SENSOR_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AHSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AHSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ahsp_pkg.sv -----
// Shared types, field layout tables and conversion functions of the record parser.
package ahsp_pkg;

   localparam int NumFields = 14;
   localparam int NumResults = NumFields + 1;
   localparam int CountW = 9;
   localparam int IndexW = 4;

   // Result codes with a fixed meaning.
   localparam logic [IndexW-1:0] FieldSupply = 4'd6;
   localparam logic [IndexW-1:0] FieldXor = 4'd14;
   localparam logic [IndexW-1:0] FieldError = 4'd0;

   // Field layout: first offset and first offset past the field.
   localparam logic [CountW-1:0] FieldStart [NumFields] = '{
      9'd1, 9'd9, 9'd11, 9'd15, 9'd23, 9'd25, 9'd27,
      9'd29, 9'd33, 9'd37, 9'd41, 9'd45, 9'd49, 9'd57};
   localparam logic [CountW-1:0] FieldEnd [NumFields] = '{
      9'd9, 9'd11, 9'd15, 9'd23, 9'd25, 9'd27, 9'd29,
      9'd33, 9'd37, 9'd41, 9'd45, 9'd49, 9'd57, 9'd59};

   // Supply conversion constants (mV).
   localparam logic [11:0] SupplyKnee = 12'd170;
   localparam logic [11:0] SupplyLowBase = 12'd1950;
   localparam logic [11:0] SupplyHighBase = 12'd2800;
   localparam logic [11:0] SupplyLowStep = 12'd5;
   localparam logic [11:0] SupplyHighStep = 12'd10;

   typedef logic [31:0] word_type;
   typedef logic [NumFields-1:0][31:0] field_arr_type;

   typedef struct packed {
      field_arr_type fields;
      logic [7:0] xor_byte;
      logic [CountW-1:0] count;
   } line_snap_type;

   // Bit 4 set means not a hex digit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] nib;
      nib = 5'h10;
      if (c inside {[8'h30:8'h39]}) begin
         nib = {1'b0, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         nib = {1'b0, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         nib = {1'b0, 4'(c - 8'h37)};
      end
      return nib;
   endfunction

   function automatic word_type supply_mv(input logic [7:0] b);
      logic [11:0] mv;
      if ({4'd0, b} <= SupplyKnee) begin
         mv = SupplyLowBase + {4'd0, b} * SupplyLowStep;
      end else begin
         mv = SupplyHighBase + ({4'd0, b} - SupplyKnee) * SupplyHighStep;
      end
      return {20'd0, mv};
   endfunction

endpackage

// ----- rtl/ascii_hex_sensor_record_parser.sv -----
// Top level of the ASCII hex sensor record parser.
//
// Takes one character of a sensor record line per request and accepts one in every cycle
// unless a line's final character is held off. Offsets 1..58 carry 14 fixed-width hex
// fields that are accumulated as the characters arrive; all characters are XORed into a
// check byte. On the character flagged last_char the line is closed: if its length
// (saturating at MAX_LENGTH, capped at 511) reaches min_length, 15 results follow, one
// per cycle while rsp_stall is low (fields 0..13 with the supply byte converted to mV,
// then the XOR byte); otherwise one error result with status set. Closing a line copies
// the fields into a result bank and clears the line state in the same cycle, so the next
// line's characters flow in while the bank drains. Only the final character of a line
// can be held off: it stalls while the previous line's bank is still draining, so lines
// shorter than 15 characters with many results are limited by the bank drain rate of one
// result per cycle while rsp_stall is low. The first result comes in the cycle after
// the last character. min_length is written through the csr port, always ready.
module ascii_hex_sensor_record_parser #(
   parameter int MAX_LENGTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // character requests
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_char_in,
   input  logic                          req_last_char,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ahsp_pkg::IndexW-1:0]   rsp_field_index,
   output logic [31:0]                   rsp_value,
   output logic                          rsp_status,
   output logic                          rsp_last_result,
   // min_length register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [7:0]                    csr_min_length
);
   import ahsp_pkg::*;
`include "ascii_hex_sensor_record_parser_defines.svh"

   localparam logic [7:0] MinLengthReset = 8'd59;

   logic                 req_accept;
   logic                 line_close;
   line_snap_type        snap_next;
   logic                 short_line;

   // config
   logic [7:0]           min_length_ff, min_length_in;

   // result bank and drain state
   word_type             bank_ff [NumResults];
   word_type             bank_in [NumResults];
   logic                 busy_ff, busy_in;
   logic                 err_ff, err_in;
   logic [IndexW-1:0]    idx_ff, idx_in;
   logic                 rsp_take;
   logic                 rsp_done;

   // ---------------------------------------------------------------
   // Line accumulation
   // ---------------------------------------------------------------
   assign req_accept = req_valid && !req_stall;
   assign line_close = req_accept && req_last_char;

   ahsp_line_acc #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_line_acc (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_in   (req_char_in),
      .last_char (req_last_char),
      .snap_next (snap_next)
   );

   assign short_line = snap_next.count < {1'b0, min_length_ff};

   // ---------------------------------------------------------------
   // Config register
   // ---------------------------------------------------------------
   assign csr_ready     = 1'b1;
   assign min_length_in = (csr_valid && csr_ready) ? csr_min_length : min_length_ff;

   // ---------------------------------------------------------------
   // Result bank: loaded on line close, drained while rsp_stall is low at one result per cycle
   // ---------------------------------------------------------------
   assign rsp_take  = busy_ff && !rsp_stall;
   assign rsp_done  = rsp_take && rsp_last_result;
   // last char needs a free bank; the bank frees up in the cycle its final result goes
   assign req_stall = req_last_char && busy_ff && !rsp_done;

   always_comb begin
      bank_in = bank_ff;
      if (line_close) begin
         for (int f = 0; f < NumFields; f++) begin
            bank_in[f] = snap_next.fields[f];
         end
         bank_in[FieldSupply] = supply_mv(snap_next.fields[FieldSupply][7:0]);
         bank_in[FieldXor]    = {24'd0, snap_next.xor_byte};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      err_in  = err_ff;
      idx_in  = idx_ff;
      if (line_close) begin
         busy_in = 1'b1;
         err_in  = short_line;
         idx_in  = '0;
      end else if (rsp_done) begin
         busy_in = 1'b0;
      end else if (rsp_take) begin
         idx_in  = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MinLengthReset;
         busy_ff       <= 1'b0;
         err_ff        <= 1'b0;
         idx_ff        <= '0;
      end else begin
         min_length_ff <= min_length_in;
         busy_ff       <= busy_in;
         err_ff        <= err_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
   end

   // ---------------------------------------------------------------
   // Result outputs
   // ---------------------------------------------------------------
   assign rsp_valid       = busy_ff;
   assign rsp_status      = err_ff;
   assign rsp_field_index = err_ff ? FieldError : idx_ff;
   assign rsp_value       = err_ff ? '0 : bank_ff[idx_ff];
   assign rsp_last_result = err_ff || (idx_ff == FieldXor);

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `AHSP_ASSERT_NOW(a_err_single, clock, reset, rsp_valid && rsp_status, rsp_last_result && rsp_field_index == FieldError && rsp_value == '0, "error result must be single and zero")
   `AHSP_ASSERT_NEXT(a_close_loads, clock, reset, line_close, rsp_valid && rsp_field_index == FieldError, "line close must present its first result next cycle")
   `AHSP_ASSERT_NEXT(a_index_steps, clock, reset, rsp_take && !rsp_last_result && !line_close, rsp_valid && rsp_field_index == IndexW'($past(rsp_field_index) + 1'b1), "result index must step by one")
   `AHSP_ASSERT_NOW(a_no_overrun, clock, reset, busy_ff && !rsp_done, !line_close, "line closed while result bank still draining")

endmodule

// ----- rtl/ahsp_line_acc.sv -----
// Per-line accumulator: character count, XOR byte and the fixed-position hex fields.
module ahsp_line_acc #(
   parameter int MAX_LENGTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             char_in,
   input  logic                   last_char,
   output ahsp_pkg::line_snap_type snap_next
);
   import ahsp_pkg::*;

   localparam int CntLimitInt = (MAX_LENGTH < 511) ? MAX_LENGTH : 511;
   localparam logic [CountW-1:0] CntLimit = CountW'(CntLimitInt);

   logic [CountW-1:0] count_ff, count_in;
   logic [7:0]        xor_ff, xor_in;
   field_arr_type     fields_ff, fields_in;
   logic              stopped_ff, stopped_in;

   logic [4:0]        nib;
   logic              stop_base;
   field_arr_type     fields_upd;
   logic              stopped_upd;

   assign nib = hex_nibble(char_in);

   always_comb begin
      fields_upd  = fields_ff;
      stopped_upd = stopped_ff;
      stop_base   = stopped_ff;
      for (int f = 0; f < NumFields; f++) begin
         if (count_ff >= FieldStart[f] && count_ff < FieldEnd[f]) begin
            stop_base = (count_ff == FieldStart[f]) ? 1'b0 : stopped_ff;
            if (!stop_base && !nib[4]) begin
               fields_upd[f] = {fields_ff[f][27:0], nib[3:0]};
               stopped_upd   = 1'b0;
            end else begin
               stopped_upd   = 1'b1;
            end
         end
      end
   end

   assign snap_next.fields   = fields_upd;
   assign snap_next.xor_byte = xor_ff ^ char_in;
   assign snap_next.count    = (count_ff < CntLimit) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      count_in   = count_ff;
      xor_in     = xor_ff;
      fields_in  = fields_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         if (last_char) begin
            count_in   = '0;
            xor_in     = '0;
            fields_in  = '0;
            stopped_in = 1'b0;
         end else begin
            count_in   = snap_next.count;
            xor_in     = snap_next.xor_byte;
            fields_in  = fields_upd;
            stopped_in = stopped_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         xor_ff     <= '0;
         fields_ff  <= '0;
         stopped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         xor_ff     <= xor_in;
         fields_ff  <= fields_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule
